@@ sv/dpf_pkg.sv @@
package dpf_pkg;

    localparam int Capacity  = 64;
    localparam int AddrW     = $clog2(Capacity);
    localparam int OccW      = $clog2(Capacity + 1);
    localparam int EntryW    = 64;

    localparam logic [1:0] KIND_ADD     = 2'd0;
    localparam logic [1:0] KIND_FORWARD = 2'd1;
    localparam logic [1:0] KIND_COUNT   = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] source;
        logic [15:0] destination;
        logic [31:0] timestamp;
        logic [31:0] start_time;
        logic [31:0] end_time;
    } req_t;

    typedef struct packed {
        logic        accepted;
        logic        packet_valid;
        logic [15:0] out_source;
        logic [15:0] out_destination;
        logic [31:0] out_timestamp;
        logic [6:0]  match_count;
    } rsp_t;

endpackage

@@ sv/dpf_ram.sv @@
module dpf_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ sv/dpf_front.sv @@
// Request intake: two-entry queue between the ports and the engine.
module dpf_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  dpf_pkg::req_t in_req,
    output logic          q_valid,
    input  logic          q_ready,
    output dpf_pkg::req_t q_req
);
    import dpf_pkg::*;

    req_t       slot_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    logic       push;
    logic       pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = slot_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= in_req;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !push)
        else $error("push into full queue");
endmodule

@@ sv/dpf_engine.sv @@
// Back end: ring store in RAM, scans one entry per cycle.
module dpf_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [6:0]    cfg_data,
    input  logic          q_valid,
    output logic          q_ready,
    input  dpf_pkg::req_t q_req,
    output logic          out_valid,
    input  logic          out_ready,
    output dpf_pkg::rsp_t out_rsp
);
    import dpf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       state_reg;
    req_t             req_reg;
    logic [6:0]       limit_reg;
    logic [AddrW-1:0] head_reg;
    logic [OccW-1:0]  occ_reg;
    logic [OccW-1:0]  idx_reg;
    logic             rvalid_reg;
    logic             dup_reg;
    logic [6:0]       count_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             ovalid_reg;

    logic [OccW-1:0]  lim_eff;
    logic [AddrW-1:0] raddr;
    logic [EntryW-1:0] rdata;
    logic [AddrW-1:0] waddr;
    logic             we;
    logic [15:0]      e_src;
    logic [15:0]      e_dst;
    logic [31:0]      e_ts;
    logic             scan_last;
    logic             evict;

    always_comb
    begin
        if (limit_reg == 7'd0)
        begin
            lim_eff = OccW'(1);
        end
        else if (32'(limit_reg) > Capacity)
        begin
            lim_eff = OccW'(Capacity);
        end
        else
        begin
            lim_eff = OccW'(limit_reg);
        end
    end

    assign raddr = head_reg + idx_reg[AddrW-1:0];
    assign {e_src, e_dst, e_ts} = rdata;
    assign scan_last = rvalid_reg && (idx_reg == occ_reg);
    assign evict = (occ_reg >= lim_eff);
    // after an eviction the head moves up one and occupancy drops one, so the
    // new tail slot is head + occupancy either way
    assign waddr = head_reg + occ_reg[AddrW-1:0];
    assign we = (state_reg == ST_DONE) && (req_reg.kind == KIND_ADD) && !dup_reg;

    dpf_ram #(.Width(EntryW), .Depth(Capacity)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata ({req_reg.source, req_reg.destination, req_reg.timestamp}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign q_ready   = (state_reg == ST_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;
    assign out_rsp   = rsp_reg;

    always_comb
    begin
        rsp_next = '0;
        case (req_reg.kind)
            KIND_ADD:
            begin
                rsp_next.accepted = !dup_reg;
            end
            KIND_FORWARD:
            begin
                if (occ_reg != '0)
                begin
                    rsp_next.packet_valid    = 1'b1;
                    rsp_next.out_source      = e_src;
                    rsp_next.out_destination = e_dst;
                    rsp_next.out_timestamp   = e_ts;
                end
            end
            KIND_COUNT:
            begin
                rsp_next.match_count = count_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            limit_reg  <= 7'd64;
            head_reg   <= '0;
            occ_reg    <= '0;
            idx_reg    <= '0;
            rvalid_reg <= 1'b0;
            dup_reg    <= 1'b0;
            count_reg  <= '0;
            rsp_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            if (ovalid_reg && out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid && q_ready)
                    begin
                        idx_reg    <= '0;
                        rvalid_reg <= 1'b0;
                        dup_reg    <= 1'b0;
                        count_reg  <= '0;
                        // every kind passes through scan; forward uses it to
                        // issue the head read
                        state_reg  <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (req_reg.kind == KIND_FORWARD || req_reg.kind == KIND_NONE)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        // read of slot idx-1 lands while idx is issued
                        if (rvalid_reg)
                        begin
                            if (e_src == req_reg.source && e_dst == req_reg.destination
                                && e_ts == req_reg.timestamp)
                            begin
                                dup_reg <= 1'b1;
                            end
                            if (e_dst == req_reg.destination && e_ts >= req_reg.start_time
                                && e_ts <= req_reg.end_time)
                            begin
                                count_reg <= count_reg + 7'd1;
                            end
                        end
                        if (occ_reg == '0 || scan_last)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            idx_reg    <= idx_reg + OccW'(1);
                            rvalid_reg <= 1'b1;
                        end
                    end
                end
                ST_DONE:
                begin
                    rsp_reg    <= rsp_next;
                    ovalid_reg <= 1'b1;
                    state_reg  <= ST_IDLE;
                    case (req_reg.kind)
                        KIND_ADD:
                        begin
                            if (!dup_reg)
                            begin
                                if (evict)
                                begin
                                    head_reg <= head_reg + AddrW'(1);
                                end
                                else
                                begin
                                    occ_reg <= occ_reg + OccW'(1);
                                end
                            end
                        end
                        KIND_FORWARD:
                        begin
                            if (occ_reg != '0)
                            begin
                                head_reg <= head_reg + AddrW'(1);
                                occ_reg  <= occ_reg - OccW'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid && q_ready)
        begin
            req_reg <= q_req;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) occ_reg <= OccW'(Capacity))
        else $error("occupancy beyond capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (state_reg == ST_DONE))
        else $error("store written outside completion");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> out_valid)
        else $error("completion without response");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_rsp))
        else $error("response changed while stalled");
endmodule

@@ sv/dedup_packet_fifo_with_range_count_core.sv @@
// Bounded packet FIFO with duplicate suppression and windowed count.
// Input channel: in_valid/in_ready carry one request (kind, source,
// destination, timestamp, start_time, end_time). Kind 0 adds a packet
// unless an identical triple is stored, evicting the oldest when at the
// limit; kind 1 pops the oldest; kind 2 counts entries for destination
// with timestamp inside [start_time, end_time]; kind 3 does nothing.
// Output channel: out_valid/out_ready carry one response per request.
// memory_limit is written via cfg_we/cfg_data (0 acts as 1, above 64 as 64).
// Scanning: an add or count reads the stored entries one per cycle through
// the store's single read port, while forward reads only the head entry. A
// two-entry request queue lets the sender keep going while the engine works.
// Reset empties the store (head and occupancy cleared), limit goes to 64.
// When the receiver stalls the response is held in its output register and
// the engine stops taking requests; the queue fills and in_ready drops.
module dedup_packet_fifo_with_range_count_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [15:0] source,
    input  logic [15:0] destination,
    input  logic [31:0] timestamp,
    input  logic [31:0] start_time,
    input  logic [31:0] end_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic        packet_valid,
    output logic [15:0] out_source,
    output logic [15:0] out_destination,
    output logic [31:0] out_timestamp,
    output logic [6:0]  match_count
);
    import dpf_pkg::*;

    req_t in_req;
    req_t q_req;
    rsp_t rsp;
    logic q_valid;
    logic q_ready;

    assign in_req = '{kind: kind, source: source, destination: destination,
                      timestamp: timestamp, start_time: start_time,
                      end_time: end_time};

    dpf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req)
    );

    dpf_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_req     (q_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rsp   (rsp)
    );

    assign accepted        = rsp.accepted;
    assign packet_valid    = rsp.packet_valid;
    assign out_source      = rsp.out_source;
    assign out_destination = rsp.out_destination;
    assign out_timestamp   = rsp.out_timestamp;
    assign match_count     = rsp.match_count;
endmodule

@@ sim/dedup_packet_fifo_with_range_count_core_test.sv @@
`timescale 1ns / 100ps

module dedup_packet_fifo_with_range_count_core_test;
    import dpf_pkg::*;

    localparam int WatchLimit = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [6:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  kind;
    logic [15:0] source;
    logic [15:0] destination;
    logic [31:0] timestamp;
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic        out_valid;
    logic        out_ready;
    logic        accepted;
    logic        packet_valid;
    logic [15:0] out_source;
    logic [15:0] out_destination;
    logic [31:0] out_timestamp;
    logic [6:0]  match_count;

    dedup_packet_fifo_with_range_count_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .source(source),
        .destination(destination), .timestamp(timestamp),
        .start_time(start_time), .end_time(end_time),
        .out_valid(out_valid), .out_ready(out_ready), .accepted(accepted),
        .packet_valid(packet_valid), .out_source(out_source),
        .out_destination(out_destination), .out_timestamp(out_timestamp),
        .match_count(match_count)
    );

    // Predictor copy of the packet store.
    logic [15:0] pkt_src [Capacity];
    logic [15:0] pkt_dst [Capacity];
    logic [31:0] pkt_ts  [Capacity];
    int          pkt_head;
    int          pkt_occ;
    int          pkt_limit;

    req_t pending_reqs[$];       // requests waiting for the driver
    rsp_t expected_rsps[$];      // predicted responses, oldest first

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int checked;
    int n_adds, n_dups, n_fwds, n_empty_fwds, n_counts;
    int quiet_cycles;
    bit hold_off;
    bit in_taken;                // request handshake seen at the last rising edge

    function automatic rsp_t predict_request(req_t r);
        rsp_t o;
        bit   dup;
        int   s;
        int   lim;
        int   n;
        o = '0;
        if (r.kind == KIND_ADD) begin
            dup = 0;
            for (int i = 0; i < pkt_occ; i++) begin
                s = (pkt_head + i) % Capacity;
                if (pkt_src[s] == r.source && pkt_dst[s] == r.destination &&
                    pkt_ts[s] == r.timestamp)
                    dup = 1;
            end
            if (!dup) begin
                lim = pkt_limit < 1 ? 1 : (pkt_limit > Capacity ? Capacity : pkt_limit);
                if (pkt_occ >= lim) begin
                    pkt_head = (pkt_head + 1) % Capacity;
                    pkt_occ--;
                end
                s = (pkt_head + pkt_occ) % Capacity;
                pkt_src[s] = r.source;
                pkt_dst[s] = r.destination;
                pkt_ts[s]  = r.timestamp;
                pkt_occ++;
                o.accepted = 1'b1;
                n_adds++;
            end else begin
                n_dups++;
            end
        end else if (r.kind == KIND_FORWARD) begin
            if (pkt_occ > 0) begin
                s = pkt_head;
                o.packet_valid    = 1'b1;
                o.out_source      = pkt_src[s];
                o.out_destination = pkt_dst[s];
                o.out_timestamp   = pkt_ts[s];
                pkt_head = (pkt_head + 1) % Capacity;
                pkt_occ--;
                n_fwds++;
            end else begin
                n_empty_fwds++;
            end
        end else if (r.kind == KIND_COUNT) begin
            n = 0;
            for (int i = 0; i < pkt_occ; i++) begin
                s = (pkt_head + i) % Capacity;
                if (pkt_dst[s] == r.destination && pkt_ts[s] >= r.start_time &&
                    pkt_ts[s] <= r.end_time)
                    n++;
            end
            o.match_count = n[6:0];
            n_counts++;
        end
        return o;
    endfunction

    function automatic req_t make_req(logic [1:0] k, logic [15:0] s, logic [15:0] d,
                                      logic [31:0] t, logic [31:0] t0,
                                      logic [31:0] t1);
        req_t r;
        r.kind = k;
        r.source = s;
        r.destination = d;
        r.timestamp = t;
        r.start_time = t0;
        r.end_time = t1;
        return r;
    endfunction

    // Random request. Sources/destinations come from a small pool most of the
    // time so duplicates and count hits happen; full-range values otherwise.
    function automatic req_t random_req();
        req_t        r;
        int          sel;
        logic [31:0] a;
        logic [31:0] b;
        sel = $urandom_range(0, 99);
        r.kind = sel < 50 ? KIND_ADD : (sel < 75 ? KIND_FORWARD :
                 (sel < 97 ? KIND_COUNT : KIND_NONE));
        if ($urandom_range(0, 3) == 0) begin
            r.source = 16'($urandom);
            r.destination = 16'($urandom);
            r.timestamp = $urandom;
        end else begin
            r.source = 16'($urandom_range(0, 3));
            r.destination = 16'($urandom_range(0, 3));
            r.timestamp = $urandom_range(0, 15);
        end
        if ($urandom_range(0, 3) == 0) begin
            a = $urandom;
            b = $urandom;
        end else begin
            a = $urandom_range(0, 16);
            b = $urandom_range(0, 16);
        end
        r.start_time = a;
        r.end_time = b;
        return r;
    endfunction

    task automatic put_req(req_t r);
        pending_reqs = {pending_reqs, r};
    endtask

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Driver: inputs move on the falling edge.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (!in_valid || in_taken) begin
                if (pending_reqs.size() > 0 && !hold_off &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    req_t r;
                    r = pending_reqs[0];
                    pending_reqs.delete(0);
                    in_valid    <= 1'b1;
                    kind        <= r.kind;
                    source      <= r.source;
                    destination <= r.destination;
                    timestamp   <= r.timestamp;
                    start_time  <= r.start_time;
                    end_time    <= r.end_time;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: predict on accepted requests, check accepted responses.
    always @(posedge clk) begin
        if (rst_n) begin
            in_taken <= in_valid && in_ready;
            quiet_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ?
                            0 : quiet_cycles + 1;
            if (in_valid && in_ready) begin
                expected_rsps = {expected_rsps, predict_request(make_req(kind, source,
                    destination, timestamp, start_time, end_time))};
            end
            if (out_valid && out_ready) begin
                checked++;
                if (expected_rsps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: response with no request outstanding");
                end
                else begin
                    rsp_t e;
                    e = expected_rsps[0];
                    expected_rsps.delete(0);
                    if (accepted !== e.accepted || packet_valid !== e.packet_valid ||
                        out_source !== e.out_source ||
                        out_destination !== e.out_destination ||
                        out_timestamp !== e.out_timestamp ||
                        match_count !== e.match_count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: exp acc=%0d vld=%0d src=%h dst=%h ts=%h cnt=%0d",
                                     e.accepted, e.packet_valid, e.out_source,
                                     e.out_destination, e.out_timestamp,
                                     e.match_count,
                                     ", got acc=%0d vld=%0d src=%h dst=%h ts=%h cnt=%0d",
                                     accepted, packet_valid,
                                     out_source, out_destination, out_timestamp,
                                     match_count);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any handshake means the block hung.
    always @(posedge clk) begin
        if (quiet_cycles >= WatchLimit) begin
            $display("timeout: no handshake for %0d cycles", WatchLimit);
            $display("dedup_packet_fifo_with_range_count_core_test NOT OK");
            $finish;
        end
    end

    // Wait until every request has been sent and answered.
    task automatic drain();
        while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // Limit writes only while the block is idle.
    task automatic set_limit(logic [6:0] v);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        pkt_limit = int'(v);
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
            put_req(random_req());
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        kind = '0;
        source = '0;
        destination = '0;
        timestamp = '0;
        start_time = '0;
        end_time = '0;
        send_idle_pct = 11;
        recv_idle_pct = 70;
        hold_off = 0;
        in_taken = 0;
        mismatches = 0;
        checked = 0;
        quiet_cycles = 0;
        n_adds = 0; n_dups = 0; n_fwds = 0; n_empty_fwds = 0; n_counts = 0;
        pkt_head = 0;
        pkt_occ = 0;
        pkt_limit = 64;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty forward, extremes, duplicate, inverted window, kind 3.
        put_req(make_req(KIND_FORWARD, 16'hffff, 16'hffff, '1, '1, '1));
        put_req(make_req(KIND_ADD, 16'h0000, 16'h0000, 32'h0, 32'd0, 32'd0));
        put_req(make_req(KIND_ADD, 16'hffff, 16'hffff, '1, 32'd0, 32'd0));
        put_req(make_req(KIND_ADD, 16'hffff, 16'hffff, '1, 32'd0, 32'd0));
        put_req(make_req(KIND_COUNT, 16'd0, 16'hffff, 32'd0, 32'd0, '1));
        put_req(make_req(KIND_COUNT, 16'd0, 16'hffff, 32'd0, '1, 32'd0));
        put_req(make_req(KIND_COUNT, 16'd0, 16'h0000, 32'd0, 32'd0, 32'd0));
        put_req(make_req(KIND_NONE, 16'h5a5a, 16'ha5a5, 32'h5a5aa5a5, 32'd1, 32'd2));
        put_req(make_req(KIND_FORWARD, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0));
        put_req(make_req(KIND_FORWARD, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0));
        put_req(make_req(KIND_FORWARD, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0));
        drain();

        // Limit 1: full after one add; duplicate of the oldest must not evict.
        set_limit(7'd1);
        put_req(make_req(KIND_ADD, 16'd1, 16'd2, 32'd3, 32'd0, 32'd0));
        put_req(make_req(KIND_ADD, 16'd1, 16'd2, 32'd3, 32'd0, 32'd0));
        put_req(make_req(KIND_ADD, 16'd4, 16'd5, 32'd6, 32'd0, 32'd0));
        put_req(make_req(KIND_COUNT, 16'd0, 16'd2, 32'd0, 32'd0, 32'd10));
        put_req(make_req(KIND_FORWARD, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0));
        queue_random(150);
        drain();

        // Limit 0 acts as 1.
        set_limit(7'd0);
        queue_random(100);
        drain();

        // Largest codes act as full capacity; fill it past the brim.
        set_limit(7'd127);
        for (int i = 0; i < 70; i++)
            put_req(make_req(KIND_ADD, i[15:0], 16'd7, 32'(i), 32'd0, 32'd0));
        put_req(make_req(KIND_COUNT, 16'd0, 16'd7, 32'd0, 32'd0, '1));
        queue_random(200);
        drain();

        // Lower the limit below occupancy, then go on.
        set_limit(7'd5);
        queue_random(200);
        drain();

        // Sender holds off mid-stream until every response is in.
        queue_random(20);
        repeat (30) @(posedge clk);
        hold_off = 1;
        while (expected_rsps.size() > 0 || in_valid) @(posedge clk);
        hold_off = 0;
        drain();

        send_idle_pct = 70;
        recv_idle_pct = 11;
        set_limit(7'd64);
        queue_random(400);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_limit(7'd65);
        queue_random(200);
        drain();
        set_limit(7'd16);
        queue_random(300);
        drain();

        $display("ran %0d responses: %0d adds, %0d duplicates, %0d forwards,",
                 checked, n_adds, n_dups, n_fwds,
                 " %0d empty forwards, %0d counts", n_empty_fwds, n_counts);
        $display("limits 0, 1, 5, 16, 64, 65, 127 under three stall patterns");
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("dedup_packet_fifo_with_range_count_core_test OK");
        else
            $display("dedup_packet_fifo_with_range_count_core_test NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
sv/dpf_pkg.sv
sv/dpf_ram.sv
sv/dpf_front.sv
sv/dpf_engine.sv
sv/dedup_packet_fifo_with_range_count_core.sv
sim/dedup_packet_fifo_with_range_count_core_test.sv
